// ===== src/wildcard_byte_signature_scan_macros.svh =====
// Assertion macros shared by the signature scan modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_MACROS_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define WBSS_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// The property must hold in the cycle after the condition.
`define WBSS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// ===== src/wbss_pkg.sv =====
// Types and constants of the wildcard byte signature scan.
// Used by the front, queue, back and top-level modules; depends on nothing.
package wbss_pkg;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int SIG_BYTES       = 16;
    localparam int LENGTH_WIDTH    = 5;
    localparam int POSITION_WIDTH  = 32;
    localparam int MATCH_ADDR_WIDTH = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] WILDCARD_BYTE = 8'hCC;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIGNATURE_LOW    = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIGNATURE_HIGH   = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIGNATURE_LENGTH = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_ADDRESS     = 8'd3;

    typedef struct packed {
        logic                      region_first;
        logic                      complete;
        logic                      hit;
        logic [POSITION_WIDTH-1:0] offset;
    } scan_entry_t;

endpackage

// ===== src/wbss_queue.sv =====
// Two-entry queue of classified bytes between the scan front and back.
// Depends on wbss_pkg and the assertion macro header.
`include "wildcard_byte_signature_scan_macros.svh"

module wbss_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wbss_pkg::scan_entry_t push_entry,
    output logic                 push_ready,
    input  logic                 pop,
    output logic                 q_valid,
    output wbss_pkg::scan_entry_t q_entry
);

    localparam int PTR_WIDTH = $clog2(wbss_pkg::QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(wbss_pkg::QUEUE_DEPTH + 1);

    wbss_pkg::scan_entry_t entry_reg [wbss_pkg::QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg;
    logic [PTR_WIDTH-1:0] wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg;
    logic [PTR_WIDTH-1:0] rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg;
    logic [CNT_WIDTH-1:0] count_next;

    assign push_ready = (count_reg != CNT_WIDTH'(wbss_pkg::QUEUE_DEPTH));
    assign q_valid    = (count_reg != '0);
    assign q_entry    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_WIDTH'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_WIDTH'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_WIDTH'(push) - CNT_WIDTH'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `WBSS_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, push, push_ready)
    `WBSS_ASSERT_IMPLY(a_no_pop_when_empty, clk, rst_n, pop, q_valid)
    `WBSS_ASSERT_NEXT(a_count_tracks, clk, rst_n, 1'b1,
        count_reg == CNT_WIDTH'($past(count_reg) + CNT_WIDTH'($past(push))
                                 - CNT_WIDTH'($past(pop))))

endmodule

// ===== src/wbss_front.sv =====
// Scan front: accepts bytes, shifts the window and compares it with the signature.
// Depends on wbss_pkg; feeds classified entries into wbss_queue.
module wbss_front #(
    parameter int MAX_SIGNATURE = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            data_byte,
    input  logic                                  region_first,
    input  logic [8*wbss_pkg::SIG_BYTES-1:0]      signature,
    input  logic [wbss_pkg::LENGTH_WIDTH-1:0]     signature_length,
    input  logic                                  push_ready,
    output logic                                  push,
    output wbss_pkg::scan_entry_t                 push_entry
);

    localparam int LW   = $clog2(MAX_SIGNATURE + 1);
    localparam int IDXW = (MAX_SIGNATURE > 1) ? $clog2(MAX_SIGNATURE) : 1;

    logic [7:0] win_reg [MAX_SIGNATURE];
    logic [7:0] win_next [MAX_SIGNATURE];
    logic [LW-1:0] fill_reg;
    logic [LW-1:0] fill_next;
    logic [wbss_pkg::POSITION_WIDTH-1:0] pos_reg;
    logic [wbss_pkg::POSITION_WIDTH-1:0] pos_next;
    logic [wbss_pkg::LENGTH_WIDTH-1:0] len_raw;
    logic [LW-1:0] len;
    logic [7:0] sig_byte;
    logic [IDXW-1:0] win_idx;
    logic hit;
    logic accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign push     = accept;

    always_comb
    begin
        if (signature_length == '0)
        begin
            len_raw = wbss_pkg::LENGTH_WIDTH'(1);
        end
        else if (signature_length > wbss_pkg::LENGTH_WIDTH'(MAX_SIGNATURE))
        begin
            len_raw = wbss_pkg::LENGTH_WIDTH'(MAX_SIGNATURE);
        end
        else
        begin
            len_raw = signature_length;
        end
        len = LW'(len_raw);
    end

    always_comb
    begin
        win_next[0] = data_byte;
        for (int k = 1; k < MAX_SIGNATURE; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
        if (region_first)
        begin
            fill_next = LW'(1);
            pos_next  = wbss_pkg::POSITION_WIDTH'(1);
        end
        else
        begin
            fill_next = (fill_reg < LW'(MAX_SIGNATURE)) ? fill_reg + LW'(1) : fill_reg;
            pos_next  = pos_reg + wbss_pkg::POSITION_WIDTH'(1);
        end
    end

    // Signature byte i lines up with the byte received len-1-i steps ago.
    always_comb
    begin
        hit      = 1'b1;
        sig_byte = '0;
        win_idx  = '0;
        for (int i = 0; i < MAX_SIGNATURE; i++)
        begin
            sig_byte = signature[8*i +: 8];
            win_idx  = IDXW'(len - LW'(1) - LW'(i));
            if ((LW'(i) < len) && (sig_byte != wbss_pkg::WILDCARD_BYTE)
                && (sig_byte != win_next[win_idx]))
            begin
                hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        push_entry.region_first = region_first;
        push_entry.complete     = (fill_next >= len);
        push_entry.hit          = hit;
        push_entry.offset       = pos_next - wbss_pkg::POSITION_WIDTH'(len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule

// ===== src/wbss_back.sv =====
// Scan back: tracks the first match of a region, forms the address, holds the result.
// Depends on wbss_pkg and the assertion macro header; drains wbss_queue.
`include "wildcard_byte_signature_scan_macros.svh"

module wbss_back #(
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  wbss_pkg::scan_entry_t                  q_entry,
    output logic                                   pop,
    input  logic [wbss_pkg::MATCH_ADDR_WIDTH-1:0]  base_address,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   match,
    output logic                                   first_match_res,
    output logic [wbss_pkg::MATCH_ADDR_WIDTH-1:0]  match_address
);

    localparam int AWE = (ADDRESS_WIDTH < wbss_pkg::MATCH_ADDR_WIDTH) ?
                         ADDRESS_WIDTH : wbss_pkg::MATCH_ADDR_WIDTH;

    logic out_valid_reg;
    logic out_valid_next;
    logic found_reg;
    logic found_next;
    logic found_cur;
    logic match_reg;
    logic match_next;
    logic first_reg;
    logic first_next;
    logic [wbss_pkg::MATCH_ADDR_WIDTH-1:0] address_reg;
    logic [wbss_pkg::MATCH_ADDR_WIDTH-1:0] address_next;
    logic [AWE-1:0] address_sum;

    assign pop             = q_valid && (!out_valid_reg || out_ready);
    assign out_valid       = out_valid_reg;
    assign match           = match_reg;
    assign first_match_res = first_reg;
    assign match_address   = address_reg;

    always_comb
    begin
        found_cur    = q_entry.region_first ? 1'b0 : found_reg;
        match_next   = q_entry.complete && q_entry.hit;
        first_next   = match_next && !found_cur;
        found_next   = pop ? (found_cur || match_next) : found_reg;
        address_sum  = base_address[AWE-1:0] + q_entry.offset[AWE-1:0];
        address_next = q_entry.complete ? wbss_pkg::MATCH_ADDR_WIDTH'(address_sum) : '0;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            match_reg   <= match_next;
            first_reg   <= first_next;
            address_reg <= address_next;
        end
    end

    `WBSS_ASSERT_IMPLY(a_first_implies_match, clk, rst_n, out_valid_reg && first_reg, match_reg)
    `WBSS_ASSERT_NEXT(a_first_sets_found, clk, rst_n, pop && first_next, found_reg)
    `WBSS_ASSERT_NEXT(a_pop_fills_output, clk, rst_n, pop, out_valid_reg)

endmodule

// ===== src/wildcard_byte_signature_scan.sv =====
// Top level of the wildcard byte signature scan: configuration registers and wiring.
// Depends on wbss_pkg, wbss_front, wbss_queue and wbss_back.
//
// Usage: bytes of a region arrive on the input channel (in_valid, in_ready,
// data_byte, region_first) in ascending address order; region_first marks the
// first byte of a new region and restarts the window, position and first-match
// tracking. Every accepted byte yields exactly one result transfer on the output
// channel (out_valid, out_ready, match, first_match_res, match_address).
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// signature_low, signature_high, signature_length and base_address at indexes
// 0 to 3; other indexes are ignored, and cfg_ready is always high.
// From input transfer to result: the window compare writes the two-entry queue
// at the input transfer, and the queue head then loads the result register once
// that register is free or its result is being taken.
// Throughput is one byte per cycle while the receiver keeps out_ready high.
// When the receiver stalls, the queue absorbs up to two further bytes and then
// in_ready drops until results are taken again.
// Reset clears the configuration to its defaults, empties the queue and the
// result register, and restarts the byte position and window fill at zero.
module wildcard_byte_signature_scan #(
    parameter int MAX_SIGNATURE = 16,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             data_byte,
    input  logic                                   region_first,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   match,
    output logic                                   first_match_res,
    output logic [wbss_pkg::MATCH_ADDR_WIDTH-1:0]  match_address,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wbss_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [wbss_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    logic [wbss_pkg::CFG_DATA_WIDTH-1:0]   sig_low_reg;
    logic [wbss_pkg::CFG_DATA_WIDTH-1:0]   sig_high_reg;
    logic [wbss_pkg::LENGTH_WIDTH-1:0]     sig_length_reg;
    logic [wbss_pkg::MATCH_ADDR_WIDTH-1:0] base_address_reg;

    logic                  push;
    logic                  push_ready;
    logic                  pop;
    logic                  q_valid;
    wbss_pkg::scan_entry_t push_entry;
    wbss_pkg::scan_entry_t q_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_low_reg      <= '0;
            sig_high_reg     <= '0;
            sig_length_reg   <= wbss_pkg::LENGTH_WIDTH'(1);
            base_address_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wbss_pkg::CFG_SIGNATURE_LOW:
                begin
                    sig_low_reg <= cfg_data;
                end
                wbss_pkg::CFG_SIGNATURE_HIGH:
                begin
                    sig_high_reg <= cfg_data;
                end
                wbss_pkg::CFG_SIGNATURE_LENGTH:
                begin
                    sig_length_reg <= cfg_data[wbss_pkg::LENGTH_WIDTH-1:0];
                end
                wbss_pkg::CFG_BASE_ADDRESS:
                begin
                    base_address_reg <= cfg_data[wbss_pkg::MATCH_ADDR_WIDTH-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    wbss_front #(
        .MAX_SIGNATURE(MAX_SIGNATURE)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .region_first    (region_first),
        .signature       ({sig_high_reg, sig_low_reg}),
        .signature_length(sig_length_reg),
        .push_ready      (push_ready),
        .push            (push),
        .push_entry      (push_entry)
    );

    wbss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .push_ready(push_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_entry   (q_entry)
    );

    wbss_back #(
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .pop            (pop),
        .base_address   (base_address_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .match          (match),
        .first_match_res(first_match_res),
        .match_address  (match_address)
    );

endmodule
